/* rtl/core/bcd_pkg.sv */
// Shared types and constants of the button click event detector.
// Depends on nothing; every other file of the block depends on it.
`default_nettype none

package bcd_pkg;

  localparam int unsigned NUM_BUTTONS    = 8;
  localparam int unsigned BTN_IDX_W      = $clog2(NUM_BUTTONS);
  localparam int unsigned TICK_WIDTH_DEF = 16;
  localparam int unsigned EV_W           = 3;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned LIMIT_W        = 16;

  // Event codes as they appear on the result word.
  typedef enum logic [EV_W-1:0] {
    EV_DOWN       = 3'd0,
    EV_UP         = 3'd1,
    EV_REPEAT     = 3'd2,
    EV_SINGLE     = 3'd3,
    EV_DOUBLE     = 3'd4,
    EV_LONG_START = 3'd5,
    EV_LONG_HOLD  = 3'd6,
    EV_NONE       = 3'd7
  } ev_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_DIVIDER = 3'd0,
    REG_DEBOUNCE     = 3'd1,
    REG_CLICK_GAP    = 3'd2,
    REG_LONG_PRESS   = 3'd3,
    REG_ACTIVE_MASK  = 3'd4,
    REG_ENABLE_MASK  = 3'd5
  } reg_idx_e;

  // Per-button control entry; the hold counter lives in a memory of its own.
  typedef struct packed {
    logic [2:0] fsm;
    logic [7:0] deb_cnt;
    logic       stable;
    logic [3:0] rep_cnt;
    ev_e        ev;
  } bcd_ctl_t;

  localparam bcd_ctl_t CTL_RESET = '{
    fsm: 3'd0, deb_cnt: 8'd0, stable: 1'b0, rep_cnt: 4'd0, ev: EV_NONE
  };

  // Timing limits that the per-button step needs.
  typedef struct packed {
    logic [7:0]         deb_limit;
    logic [LIMIT_W-1:0] gap_limit;
    logic [LIMIT_W-1:0] press_limit;
  } bcd_cfg_t;

  // Outcome of one button visit.
  typedef struct packed {
    logic raised;
    ev_e  raised_event;
    ev_e  current_event;
  } bcd_res_t;

endpackage

`default_nettype wire

/* rtl/core/bcd_intf.sv */
// Channel interfaces of the button click event detector: tick input,
// result output and configuration writes. Depends on bcd_pkg.
`default_nettype none

interface bcd_in_if;
  logic                         valid;
  logic                         ready;
  logic [bcd_pkg::NUM_BUTTONS-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bcd_out_if;
  logic                       valid;
  logic                       ready;
  logic [bcd_pkg::BTN_IDX_W-1:0] button_index;
  logic                       raised;
  logic [bcd_pkg::EV_W-1:0]   raised_event;
  logic [bcd_pkg::EV_W-1:0]   current_event;
  logic                       last;

  modport source (output valid, output button_index, output raised, output raised_event,
                  output current_event, output last, input ready);
  modport sink   (input valid, input button_index, input raised, input raised_event,
                  input current_event, input last, output ready);
endinterface

interface bcd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bcd_pkg::CFG_IDX_W-1:0]  index;
  logic [bcd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bcd_visit.sv */
// One step of a single button: debounce, hold counting and click state machine.
// Purely combinational; depends on bcd_pkg.
`default_nettype none

module bcd_visit #(
  parameter int unsigned TICK_WIDTH = bcd_pkg::TICK_WIDTH_DEF
) (
  input  bcd_pkg::bcd_cfg_t     cfg_i,
  input  logic                  level_i,
  input  logic                  active_i,
  input  bcd_pkg::bcd_ctl_t     ctl_i,
  input  logic [TICK_WIDTH-1:0] hold_i,
  output bcd_pkg::bcd_ctl_t     ctl_o,
  output logic [TICK_WIDTH-1:0] hold_o,
  output bcd_pkg::bcd_res_t     res_o
);
  import bcd_pkg::*;

  localparam int unsigned CMP_W = (TICK_WIDTH > LIMIT_W) ? TICK_WIDTH : LIMIT_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DOWN   = 3'd1,
    ST_UP     = 3'd2,
    ST_REPEAT = 3'd3,
    ST_LONG   = 3'd5
  } st_e;

  logic [TICK_WIDTH-1:0] hold_inc;
  logic [CMP_W-1:0]      hold_cmp;
  logic [CMP_W-1:0]      short_cmp;
  logic [CMP_W-1:0]      long_cmp;
  logic [7:0]            deb_inc;
  logic                  stable_new;
  logic [7:0]            deb_new;
  logic                  pressed;

  always_comb begin
    hold_inc = hold_i;
    if (ctl_i.fsm != ST_IDLE && hold_i != '1) begin
      hold_inc = hold_i + TICK_WIDTH'(1);
    end
    hold_cmp  = CMP_W'(hold_inc);
    short_cmp = CMP_W'(cfg_i.gap_limit);
    long_cmp  = CMP_W'(cfg_i.press_limit);

    // A changed level must persist for the configured number of passes.
    stable_new = ctl_i.stable;
    deb_new    = 8'd0;
    deb_inc    = (ctl_i.deb_cnt != 8'hFF) ? ctl_i.deb_cnt + 8'd1 : ctl_i.deb_cnt;
    if (level_i != ctl_i.stable) begin
      if (deb_inc >= cfg_i.deb_limit) begin
        stable_new = level_i;
      end else begin
        deb_new = deb_inc;
      end
    end
    pressed = (stable_new == active_i);

    ctl_o         = ctl_i;
    ctl_o.deb_cnt = deb_new;
    ctl_o.stable  = stable_new;
    hold_o        = hold_inc;
    res_o.raised       = 1'b0;
    res_o.raised_event = EV_DOWN;

    case (ctl_i.fsm)
      ST_IDLE: begin
        if (pressed) begin
          ctl_o.ev      = EV_DOWN;
          res_o.raised  = 1'b1;
          hold_o        = '0;
          ctl_o.rep_cnt = 4'd1;
          ctl_o.fsm     = ST_DOWN;
        end else begin
          ctl_o.ev = EV_NONE;
        end
      end
      ST_DOWN: begin
        if (!pressed) begin
          ctl_o.ev           = EV_UP;
          res_o.raised       = 1'b1;
          res_o.raised_event = EV_UP;
          hold_o             = '0;
          ctl_o.fsm          = ST_UP;
        end else if (hold_cmp > long_cmp) begin
          ctl_o.ev           = EV_LONG_START;
          res_o.raised       = 1'b1;
          res_o.raised_event = EV_LONG_START;
          ctl_o.fsm          = ST_LONG;
        end
      end
      ST_UP: begin
        if (pressed) begin
          ctl_o.ev = EV_DOWN;
          if (ctl_i.rep_cnt != 4'hF) begin
            ctl_o.rep_cnt = ctl_i.rep_cnt + 4'd1;
          end
          res_o.raised       = 1'b1;
          res_o.raised_event = EV_REPEAT;
          hold_o             = '0;
          ctl_o.fsm          = ST_REPEAT;
        end else if (hold_cmp > short_cmp) begin
          // The click gap has run out; three or more presses raise nothing.
          if (ctl_i.rep_cnt == 4'd1) begin
            ctl_o.ev           = EV_SINGLE;
            res_o.raised       = 1'b1;
            res_o.raised_event = EV_SINGLE;
          end else if (ctl_i.rep_cnt == 4'd2) begin
            ctl_o.ev           = EV_DOUBLE;
            res_o.raised       = 1'b1;
            res_o.raised_event = EV_DOUBLE;
          end
          ctl_o.fsm = ST_IDLE;
        end
      end
      ST_REPEAT: begin
        if (!pressed) begin
          ctl_o.ev           = EV_UP;
          res_o.raised       = 1'b1;
          res_o.raised_event = EV_UP;
          if (hold_cmp < short_cmp) begin
            hold_o    = '0;
            ctl_o.fsm = ST_UP;
          end else begin
            ctl_o.fsm = ST_IDLE;
          end
        end else if (hold_cmp > short_cmp) begin
          ctl_o.fsm = ST_IDLE;
        end
      end
      ST_LONG: begin
        res_o.raised = 1'b1;
        if (pressed) begin
          ctl_o.ev           = EV_LONG_HOLD;
          res_o.raised_event = EV_LONG_HOLD;
        end else begin
          ctl_o.ev           = EV_UP;
          res_o.raised_event = EV_UP;
          ctl_o.fsm          = ST_IDLE;
        end
      end
      default: begin
        ctl_o.fsm = ST_IDLE;
      end
    endcase

    res_o.current_event = ctl_o.ev;
  end

endmodule

`default_nettype wire

/* rtl/core/button_click_event_detector.sv */
// Top level of the button click event detector: tick divider, button scan
// sequencer, per-button state memories and result register. Depends on
// bcd_pkg, the channel interfaces in bcd_intf.sv and bcd_visit.
//
//  Channel  Direction  Word carried                                   Accepted when
//  in_i     sink       pin_levels                                     valid && ready
//  out_o    source     button_index, raised, raised_event,            valid && ready
//                      current_event, last
//  cfg_i    sink       index, data (six registers)                    valid && ready
//
// A raw tick that does not start a processing pass leaves the sequencer idle. A
// tick that starts a pass scans the button indexes one per cycle while results
// are not stalled, up to the last enabled button, each enabled button costing
// one memory read and one write back; a new tick waits for the last write back.
// Reset clears the entry valid bits at once, so there is no clearing pass;
// an entry never written reads as its reset value. A stalled result word holds
// the scan, and the scan resumes on the cycle the word is taken.
`default_nettype none

module button_click_event_detector #(
  parameter int unsigned TICK_WIDTH = bcd_pkg::TICK_WIDTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  bcd_in_if.sink     in_i,
  bcd_out_if.source  out_o,
  bcd_cfg_if.sink    cfg_i
);
  import bcd_pkg::*;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_SCAN
  } seq_e;

  // Configuration registers.
  logic [7:0]             tick_div_q;
  logic [7:0]             deb_ticks_q;
  logic [LIMIT_W-1:0]     gap_lim_q;
  logic [LIMIT_W-1:0]     press_lim_q;
  logic [NUM_BUTTONS-1:0] active_q;
  logic [NUM_BUTTONS-1:0] enable_q;

  // Sequencer and pipeline registers.
  seq_e                   seq_q;
  logic [7:0]             div_q;
  logic [7:0]             div_d;
  logic [BTN_IDX_W-1:0]   idx_q;
  logic [NUM_BUTTONS-1:0] pins_q;
  logic                   s1_vld_q;
  logic [BTN_IDX_W-1:0]   s1_idx_q;
  logic                   s1_last_q;

  // Result register.
  logic                   out_vld_q;
  logic [BTN_IDX_W-1:0]   out_idx_q;
  bcd_res_t               out_res_q;
  logic                   out_last_q;

  // State memories, their read registers and the entry valid bits.
  bcd_ctl_t               ctl_mem [NUM_BUTTONS];
  logic [TICK_WIDTH-1:0]  hold_mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] ent_vld_q;
  bcd_ctl_t               rd_ctl_q;
  logic [TICK_WIDTH-1:0]  rd_hold_q;
  logic                   rd_vld_q;

  logic                   in_acc;
  logic                   advance;
  logic                   issue;
  logic                   cur_last;
  logic                   mem_we;
  bcd_cfg_t               vis_cfg;
  bcd_ctl_t               vis_ctl_in;
  logic [TICK_WIDTH-1:0]  vis_hold_in;
  bcd_ctl_t               vis_ctl_out;
  logic [TICK_WIDTH-1:0]  vis_hold_out;
  bcd_res_t               vis_res;

  // A new tick is only taken once the previous pass has written back its last
  // entry; this keeps reads of a pass clear of the writes of the one before.
  assign in_i.ready  = (seq_q == SEQ_IDLE) && !s1_vld_q;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // The scan moves only when the result register can take what stage one holds.
  assign advance  = !out_vld_q || out_o.ready;
  assign issue    = (seq_q == SEQ_SCAN) && advance && enable_q[idx_q];
  assign cur_last = ((enable_q >> idx_q) >> 1) == '0;
  assign mem_we   = s1_vld_q && advance;
  assign div_d    = div_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q  <= 8'd10;
      deb_ticks_q <= 8'd3;
      gap_lim_q   <= LIMIT_W'(30);
      press_lim_q <= LIMIT_W'(100);
      active_q    <= '0;
      enable_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TICK_DIVIDER: tick_div_q  <= cfg_i.data[7:0];
        REG_DEBOUNCE:     deb_ticks_q <= cfg_i.data[7:0];
        REG_CLICK_GAP:    gap_lim_q   <= cfg_i.data[LIMIT_W-1:0];
        REG_LONG_PRESS:   press_lim_q <= cfg_i.data[LIMIT_W-1:0];
        REG_ACTIVE_MASK:  active_q    <= cfg_i.data[NUM_BUTTONS-1:0];
        REG_ENABLE_MASK:  enable_q    <= cfg_i.data[NUM_BUTTONS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and the registered result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SEQ_IDLE;
      div_q     <= 8'd0;
      idx_q     <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      case (seq_q)
        SEQ_IDLE: begin
          if (in_acc) begin
            if (div_d >= tick_div_q) begin
              div_q <= 8'd0;
              idx_q <= '0;
              // With no button enabled a pass gives no words at all.
              if (enable_q != '0) begin
                seq_q <= SEQ_SCAN;
              end
            end else begin
              div_q <= div_d;
            end
          end
        end
        SEQ_SCAN: begin
          if (advance) begin
            idx_q <= idx_q + BTN_IDX_W'(1);
            if (idx_q == BTN_IDX_W'(NUM_BUTTONS - 1) || (enable_q[idx_q] && cur_last)) begin
              seq_q <= SEQ_IDLE;
            end
          end
        end
        default: begin
          seq_q <= SEQ_IDLE;
        end
      endcase

      if (advance) begin
        s1_vld_q <= issue;
      end

      if (mem_we) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pins_q <= in_i.pin_levels;
    end
    if (issue) begin
      s1_idx_q  <= idx_q;
      s1_last_q <= cur_last;
    end
    if (mem_we) begin
      out_idx_q  <= s1_idx_q;
      out_res_q  <= vis_res;
      out_last_q <= s1_last_q;
    end
  end

  // Read-modify-write of the per-button entries: read on issue, written back when
  // stage one hands its word to the result register.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_ctl_q  <= ctl_mem[idx_q];
      rd_hold_q <= hold_mem[idx_q];
    end
    if (mem_we) begin
      ctl_mem[s1_idx_q]  <= vis_ctl_out;
      hold_mem[s1_idx_q] <= vis_hold_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (issue) begin
        rd_vld_q <= ent_vld_q[idx_q];
      end
      if (mem_we) begin
        ent_vld_q[s1_idx_q] <= 1'b1;
      end
    end
  end

  assign vis_ctl_in  = rd_vld_q ? rd_ctl_q : CTL_RESET;
  assign vis_hold_in = rd_vld_q ? rd_hold_q : '0;

  assign vis_cfg.deb_limit   = deb_ticks_q;
  assign vis_cfg.gap_limit   = gap_lim_q;
  assign vis_cfg.press_limit = press_lim_q;

  bcd_visit #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_visit (
    .cfg_i    (vis_cfg),
    .level_i  (pins_q[s1_idx_q]),
    .active_i (active_q[s1_idx_q]),
    .ctl_i    (vis_ctl_in),
    .hold_i   (vis_hold_in),
    .ctl_o    (vis_ctl_out),
    .hold_o   (vis_hold_out),
    .res_o    (vis_res)
  );

  assign out_o.valid         = out_vld_q;
  assign out_o.button_index  = out_idx_q;
  assign out_o.raised        = out_res_q.raised;
  assign out_o.raised_event  = out_res_q.raised_event;
  assign out_o.current_event = out_res_q.current_event;
  assign out_o.last          = out_last_q;

  // Only enabled buttons are ever written back.
  a_we_enabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> enable_q[s1_idx_q])
    else $error("write back of a disabled button");

  // Once the scan has finished, whatever stage one still holds ends the pass.
  a_idle_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_IDLE && s1_vld_q) |-> s1_last_q)
    else $error("pass ended without a final word in flight");

  // A stalled stage one keeps its button.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !advance) |=> (s1_vld_q && $stable(s1_idx_q)))
    else $error("stage one lost its entry while stalled");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench of button_click_event_detector: random and directed pin
// ticks, a predictor of every result word and a field-by-field check.
// Depends on bcd_pkg, the channel interfaces and the top level of the block.
`default_nettype none

module testbench;
  import bcd_pkg::*;

  // Pause that lets a scan with no result words run out before registers change.
  localparam int unsigned SETTLE_CYCLES = 2 * (NUM_BUTTONS + 1) + 4;
  // Generous ceiling on the whole run.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  // States of the per-button click machine.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DOWN    = 3'd1;
  localparam logic [2:0] ST_UP      = 3'd2;
  localparam logic [2:0] ST_REPEAT  = 3'd3;
  localparam logic [2:0] ST_LONG    = 3'd5;
  localparam logic [TICK_WIDTH_DEF-1:0] HOLD_MAX = '1;

  // One result word as the block should present it.
  typedef struct packed {
    logic [BTN_IDX_W-1:0] button_index;
    logic                 raised;
    ev_e                  raised_event;
    ev_e                  current_event;
    logic                 last;
  } click_word_t;

  logic clk_i;
  logic rst_ni;

  bcd_in_if  tick_if ();
  bcd_out_if result_if ();
  bcd_cfg_if cfg_if ();

  button_click_event_detector uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (result_if),
    .cfg_i  (cfg_if)
  );

  // Pin words waiting to be offered, and the result words the predictor expects.
  logic [NUM_BUTTONS-1:0] pending_pins [$];
  click_word_t            expected_words [$];
  int unsigned            mismatches = 0;

  // Handshake bookkeeping of the two random sides.
  logic tick_fire = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  bit   idle_on = 1'b1;

  // The predictor's copy of the registers, updated only by accepted writes.
  logic [7:0]  pass_divider = 8'd10;
  logic [7:0]  debounce_limit = 8'd3;
  logic [15:0] click_gap_limit = 16'd30;
  logic [15:0] long_press_limit = 16'd100;
  logic [7:0]  press_polarity = 8'h00;
  logic [7:0]  scan_mask = 8'h00;

  // The predictor's copy of the divider and of each button's state.
  logic [7:0]                tick_count = 8'd0;
  logic [2:0]                btn_state    [NUM_BUTTONS];
  logic [TICK_WIDTH_DEF-1:0] btn_hold     [NUM_BUTTONS];
  logic [7:0]                btn_debounce [NUM_BUTTONS];
  logic                      btn_level    [NUM_BUTTONS];
  logic [3:0]                btn_clicks   [NUM_BUTTONS];
  ev_e                       btn_event    [NUM_BUTTONS];

  // Settings the stimulus is shaped for, and the pattern each button is following.
  logic [7:0]  plan_divider;
  logic [7:0]  plan_debounce;
  logic [15:0] plan_short;
  logic [15:0] plan_long;
  logic [7:0]  plan_active;
  int          plan_noise;
  logic [NUM_BUTTONS-1:0] held = '0;
  int          run_left [NUM_BUTTONS];

  // Directed press pattern, one mask per tick, for a divider of one, a debounce of
  // one pass and both time limits at two passes. It walks through an idle start,
  // press down, long press start and hold, release, a single click, and then a double
  // click on the low nibble while the high nibble clicks three times and times out.
  localparam logic [7:0] DIRECTED_HELD [21] = '{
    8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Clock, and every input of the block at a known value from time zero.
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    tick_if.valid = 1'b0;
    tick_if.pin_levels = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle length for either side: mostly none, often a few cycles, now and then long.
  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Ticks that a button keeps its new level for. Presses are mostly quick clicks or
  // long holds; releases are mostly short enough to chain clicks or long enough to
  // end the click sequence. Debounce time is added so that most changes are accepted.
  function automatic int draw_run(logic pressing);
    int settle, span, hold_span, pick, passes, ticks;
    settle = (plan_debounce > 40) ? 41 : plan_debounce + 1;
    span = (plan_short > 40) ? 40 : plan_short;
    hold_span = (plan_long > 40) ? 40 : plan_long;
    pick = $urandom_range(0, 99);
    if (pressing && pick < 55) begin
      passes = settle + $urandom_range(0, span / 2);
    end else if (pressing && pick < 85) begin
      passes = settle + hold_span + $urandom_range(1, 4);
    end else if (!pressing && pick < 50) begin
      passes = settle + $urandom_range(0, span / 2);
    end else if (!pressing && pick < 85) begin
      passes = settle + span + $urandom_range(1, 5);
    end else begin
      passes = $urandom_range(1, span + 4);
    end
    ticks = passes * ((plan_divider == 0) ? 1 : plan_divider);
    return (ticks > 400) ? 400 : ticks;
  endfunction

  // Queues button traffic under the current plan: each button follows its own press
  // and release pattern, with single-tick glitches and whole random words as noise.
  task automatic queue_button_traffic(int count);
    logic [NUM_BUTTONS-1:0] pins;
    int k, b;
    for (k = 0; k < count; k++) begin
      for (b = 0; b < NUM_BUTTONS; b++) begin
        if (run_left[b] <= 0) begin
          held[b] = ~held[b];
          run_left[b] = draw_run(held[b]);
        end
        run_left[b]--;
      end
      pins = ~(held ^ plan_active);
      for (b = 0; b < NUM_BUTTONS; b++) begin
        if ($urandom_range(0, 99) < plan_noise) pins[b] = ~pins[b];
      end
      if ($urandom_range(0, 99) < plan_noise / 2) pins = NUM_BUTTONS'($urandom_range(0, 255));
      pending_pins.insert(pending_pins.size(), pins);
    end
  endtask

  // Applies an accepted register write to the predictor's copy of the registers.
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_TICK_DIVIDER: pass_divider = value[7:0];
      REG_DEBOUNCE:     debounce_limit = value[7:0];
      REG_CLICK_GAP:    click_gap_limit = value;
      REG_LONG_PRESS:   long_press_limit = value;
      REG_ACTIVE_MASK:  press_polarity = value[7:0];
      REG_ENABLE_MASK:  scan_mask = value[7:0];
      default: ;
    endcase
  endfunction

  // Works out the result words of one accepted raw tick. Only every pass_divider-th
  // tick runs a pass; a pass visits every enabled button in index order and gives one
  // word each, the final one marked last.
  function automatic void predict_tick(logic [NUM_BUTTONS-1:0] pins);
    click_word_t word;
    logic        pressed;
    logic        raised;
    ev_e         fired;
    int          b, first;
    tick_count = tick_count + 8'd1;
    if (tick_count < pass_divider) return;
    tick_count = 8'd0;
    first = expected_words.size();
    for (b = 0; b < NUM_BUTTONS; b++) begin
      if (scan_mask[b]) begin
        raised = 1'b0;
        fired = EV_DOWN;
        // Hold time runs whenever the machine is away from idle, and saturates.
        if (btn_state[b] != ST_IDLE && btn_hold[b] != HOLD_MAX) btn_hold[b]++;
        // A changed level is taken once it has persisted for the debounce limit.
        if (pins[b] != btn_level[b]) begin
          if (btn_debounce[b] != 8'hFF) btn_debounce[b]++;
          if (btn_debounce[b] >= debounce_limit) begin
            btn_level[b] = pins[b];
            btn_debounce[b] = 8'd0;
          end
        end else begin
          btn_debounce[b] = 8'd0;
        end
        pressed = (btn_level[b] == press_polarity[b]);
        case (btn_state[b])
          ST_IDLE: begin
            if (pressed) begin
              btn_event[b] = EV_DOWN;
              fired = EV_DOWN;
              raised = 1'b1;
              btn_hold[b] = '0;
              btn_clicks[b] = 4'd1;
              btn_state[b] = ST_DOWN;
            end else begin
              btn_event[b] = EV_NONE;
            end
          end
          ST_DOWN: begin
            if (!pressed) begin
              btn_event[b] = EV_UP;
              fired = EV_UP;
              raised = 1'b1;
              btn_hold[b] = '0;
              btn_state[b] = ST_UP;
            end else if (btn_hold[b] > long_press_limit) begin
              btn_event[b] = EV_LONG_START;
              fired = EV_LONG_START;
              raised = 1'b1;
              btn_state[b] = ST_LONG;
            end
          end
          ST_UP: begin
            if (pressed) begin
              // A further press inside the gap: repeat is raised but down is kept.
              btn_event[b] = EV_DOWN;
              if (btn_clicks[b] != 4'd15) btn_clicks[b]++;
              fired = EV_REPEAT;
              raised = 1'b1;
              btn_hold[b] = '0;
              btn_state[b] = ST_REPEAT;
            end else if (btn_hold[b] > click_gap_limit) begin
              // Gap over: one click is single, two double, more end silently.
              if (btn_clicks[b] == 4'd1) begin
                btn_event[b] = EV_SINGLE;
                fired = EV_SINGLE;
                raised = 1'b1;
              end else if (btn_clicks[b] == 4'd2) begin
                btn_event[b] = EV_DOUBLE;
                fired = EV_DOUBLE;
                raised = 1'b1;
              end
              btn_state[b] = ST_IDLE;
            end
          end
          ST_REPEAT: begin
            if (!pressed) begin
              btn_event[b] = EV_UP;
              fired = EV_UP;
              raised = 1'b1;
              if (btn_hold[b] < click_gap_limit) begin
                btn_hold[b] = '0;
                btn_state[b] = ST_UP;
              end else begin
                btn_state[b] = ST_IDLE;
              end
            end else if (btn_hold[b] > click_gap_limit) begin
              btn_state[b] = ST_IDLE;
            end
          end
          ST_LONG: begin
            if (pressed) begin
              btn_event[b] = EV_LONG_HOLD;
              fired = EV_LONG_HOLD;
            end else begin
              btn_event[b] = EV_UP;
              fired = EV_UP;
              btn_state[b] = ST_IDLE;
            end
            raised = 1'b1;
          end
          default: btn_state[b] = ST_IDLE;
        endcase
        word.button_index = b[BTN_IDX_W-1:0];
        word.raised = raised;
        word.raised_event = fired;
        word.current_event = btn_event[b];
        word.last = 1'b0;
        expected_words.insert(expected_words.size(), word);
      end
    end
    if (expected_words.size() > first) begin
      word = expected_words.pop_back();
      word.last = 1'b1;
      expected_words.insert(expected_words.size(), word);
    end
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Takes one result word off the channel and checks it against the oldest expectation.
  task automatic check_word();
    click_word_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual button %0d event %0d/%0d last %0b",
               $time, result_if.button_index, result_if.raised_event,
               result_if.current_event, result_if.last);
      mismatches++;
    end else begin
      want = expected_words.pop_front();
      compare_field("button_index", 32'(want.button_index), 32'(result_if.button_index));
      compare_field("raised", 32'(want.raised), 32'(result_if.raised));
      compare_field("raised_event", 32'(want.raised_event), 32'(result_if.raised_event));
      compare_field("current_event", 32'(want.current_event),
                    32'(result_if.current_event));
      compare_field("last", 32'(want.last), 32'(result_if.last));
    end
  endtask

  // Monitor: everything that crosses a channel is seen at the rising edge. Register
  // writes and ticks are fed to the predictor before result words are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      tick_fire <= tick_if.valid && tick_if.ready;
      if (cfg_if.valid && cfg_if.ready) apply_register(cfg_if.index, cfg_if.data);
      if (tick_if.valid && tick_if.ready) predict_tick(tick_if.pin_levels);
      if (result_if.valid && result_if.ready) check_word();
    end
  end

  // Tick driver: offers the next pin word once the last one has been taken, with a
  // random gap after each accepted word while idling is switched on.
  always @(negedge clk_i) begin
    if (rst_ni && (!tick_if.valid || tick_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
        tick_if.valid <= 1'b0;
      end else if (pending_pins.size() != 0) begin
        tick_if.valid <= 1'b1;
        tick_if.pin_levels <= pending_pins.pop_front();
        gap_left = idle_on ? draw_gap() : 0;
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: ready drops for stalls of random length, independent of valid.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = idle_on ? draw_gap() : 0;
      end
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Writes all six registers, plus one index the block does not decode. The 8-bit
  // registers get random upper data bits, which the block must drop.
  task automatic program_settings(logic [7:0] divider, logic [7:0] debounce,
                                  logic [15:0] short_lim, logic [15:0] long_lim,
                                  logic [7:0] active, logic [7:0] enable, int noise);
    int b;
    write_register(REG_TICK_DIVIDER, {8'($urandom_range(0, 255)), divider});
    write_register(REG_DEBOUNCE, {8'($urandom_range(0, 255)), debounce});
    write_register(REG_CLICK_GAP, short_lim);
    write_register(REG_LONG_PRESS, long_lim);
    write_register(REG_ACTIVE_MASK, {8'($urandom_range(0, 255)), active});
    write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                   16'($urandom_range(0, 65535)));
    write_register(REG_ENABLE_MASK, {8'($urandom_range(0, 255)), enable});
    plan_divider = divider;
    plan_debounce = debounce;
    plan_short = short_lim;
    plan_long = long_lim;
    plan_active = active;
    plan_noise = noise;
    for (b = 0; b < NUM_BUTTONS; b++) run_left[b] = 0;
  endtask

  // Waits until every pin word has been taken and every expected word has arrived,
  // then lets a scan that gives no words finish.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_pins.size() != 0 || tick_if.valid || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("button_click_event_detector verification failed");
    $finish;
  end

  initial begin : stimulus
    int b, k;
    for (b = 0; b < NUM_BUTTONS; b++) begin
      btn_state[b] = ST_IDLE;
      btn_hold[b] = '0;
      btn_debounce[b] = 8'd0;
      btn_level[b] = 1'b0;
      btn_clicks[b] = 4'd0;
      btn_event[b] = EV_NONE;
      run_left[b] = 0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk through every event, low-level presses so that the pins swing
    // between all ones and all zeros.
    program_settings(8'd1, 8'd1, 16'd2, 16'd2, 8'h00, 8'hFF, 0);
    for (k = 0; k < 21; k++) begin
      pending_pins.insert(pending_pins.size(), ~(DIRECTED_HELD[k] ^ plan_active));
    end
    wait_drained();

    // Zero divider and zero debounce: a pass on every tick and changes taken at once.
    // Halfway through, the sender holds off until every word has come back.
    program_settings(8'd0, 8'd0, 16'd2, 16'd3, 8'hFF, 8'hFF, 4);
    queue_button_traffic(20);
    wait_drained();
    queue_button_traffic(20);
    wait_drained();

    program_settings(8'd1, 8'd2, 16'd5, 16'd8, 8'($urandom_range(0, 255)),
                     8'($urandom_range(1, 255)), 6);
    queue_button_traffic(40);
    wait_drained();

    // Every register at its top value; one pass in the whole phase, without idling.
    idle_on = 1'b0;
    program_settings(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 6);
    queue_button_traffic(260);
    wait_drained();

    // Both time limits at one, still without idling.
    program_settings(8'd3, 8'd1, 16'd1, 16'd1, 8'($urandom_range(0, 255)),
                     8'($urandom_range(1, 255)), 5);
    queue_button_traffic(40);
    wait_drained();
    idle_on = 1'b1;

    // No button enabled: ticks are taken but no word may appear.
    program_settings(8'd2, 8'd1, 16'd4, 16'd6, 8'($urandom_range(0, 255)), 8'h00, 5);
    queue_button_traffic(15);
    wait_drained();

    program_settings(8'd1, 8'd3, 16'd6, 16'd10, 8'($urandom_range(0, 255)), 8'hFF, 5);
    queue_button_traffic(40);
    wait_drained();

    if (mismatches == 0) begin
      $display("button_click_event_detector verification clean");
    end else begin
      $display("button_click_event_detector verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/bcd_pkg.sv
rtl/core/bcd_intf.sv
rtl/core/bcd_visit.sv
rtl/core/button_click_event_detector.sv
dv/testbench.sv
